/* rtl/puf_pkg.sv */
package puf_pkg;

  // Default sizes
  localparam int MAX_ROW_BYTES_DEF   = 4096;
  localparam int MAX_PIXEL_BYTES_DEF = 8;

  // Field and register widths
  localparam int FTYPE_W   = 3;
  localparam int BYTE_W    = 8;
  localparam int BPP_W     = 4;
  localparam int ROW_LEN_W = 13;
  localparam int POS_OUT_W = 12;

  // Queue depths
  localparam int CMD_Q_DEPTH = 2;
  localparam int OUT_Q_DEPTH = 2;

  // Filter types
  localparam logic [FTYPE_W-1:0] FT_NONE  = 3'd0;
  localparam logic [FTYPE_W-1:0] FT_SUB   = 3'd1;
  localparam logic [FTYPE_W-1:0] FT_UP    = 3'd2;
  localparam logic [FTYPE_W-1:0] FT_AVG   = 3'd3;
  localparam logic [FTYPE_W-1:0] FT_PAETH = 3'd4;

  // Register indexes
  localparam logic CFG_BPP     = 1'b0;
  localparam logic CFG_ROW_LEN = 1'b1;

  // Register reset values
  localparam logic [BPP_W-1:0]     BPP_RESET     = 4'd1;
  localparam logic [ROW_LEN_W-1:0] ROW_LEN_RESET = 13'd4096;

  // Classified item from front to back
  typedef struct packed {
    logic [FTYPE_W-1:0] ftype;
    logic [BYTE_W-1:0]  raw;
    logic               no_prior;
    logic               last;
    logic               invalid;
  } puf_cmd_t;

  // Finished item from back to the result queue
  typedef struct packed {
    logic [BYTE_W-1:0] recon;
    logic [BYTE_W-1:0] pred;
    logic              last;
    logic              invalid;
  } puf_res_t;

  // Paeth predictor: pick the neighbor nearest to a + b - c
  function automatic logic [BYTE_W-1:0] paeth_pred(input logic [BYTE_W-1:0] a,
                                                   input logic [BYTE_W-1:0] b,
                                                   input logic [BYTE_W-1:0] c);
    logic signed [9:0] da;
    logic signed [9:0] db;
    logic signed [9:0] dc;
    logic [9:0] pa;
    logic [9:0] pb;
    logic [9:0] pc;
    logic [BYTE_W-1:0] res;
    da = signed'(10'(b)) - signed'(10'(c));
    db = signed'(10'(a)) - signed'(10'(c));
    dc = signed'(10'(a)) + signed'(10'(b)) - signed'({1'b0, c, 1'b0});
    pa = da[9] ? 10'(-da) : 10'(da);
    pb = db[9] ? 10'(-db) : 10'(db);
    pc = dc[9] ? 10'(-dc) : 10'(dc);
    if (pa <= pb && pa <= pc) begin
      res = a;
    end else if (pb <= pc) begin
      res = b;
    end else begin
      res = c;
    end
    return res;
  endfunction

endpackage

/* rtl/puf_queue.sv */
module puf_queue import puf_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = CMD_Q_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = slot_r[rd_ptr_r];

  // Pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

/* rtl/puf_front.sv */
module puf_front import puf_pkg::*; #(
  parameter int MAX_ROW_BYTES = MAX_ROW_BYTES_DEF,
  localparam int PW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [ROW_LEN_W-1:0] row_length,
  input  logic                 in_push,
  input  logic [FTYPE_W-1:0]   in_filter_type,
  input  logic [BYTE_W-1:0]    in_raw_byte,
  input  logic                 in_no_prior_row,
  input  logic                 q_full,
  output logic                 q_push,
  output logic [PW-1:0]        q_pos,
  output puf_cmd_t             q_cmd
);

  logic [PW-1:0] pos_r, pos_nxt;
  logic [16:0]   len_ext;
  logic [PW-1:0] len_m1;
  logic          last;

  // Effective row length minus one, clamped to 1..MAX_ROW_BYTES
  assign len_ext = 17'(row_length);
  always_comb begin
    if (len_ext == '0) begin
      len_m1 = '0;
    end else if (len_ext > 17'(MAX_ROW_BYTES)) begin
      len_m1 = PW'(MAX_ROW_BYTES - 1);
    end else begin
      len_m1 = PW'(len_ext - 17'd1);
    end
  end

  assign last   = (pos_r >= len_m1);
  assign q_push = in_push & ~q_full;
  assign q_pos  = pos_r;

  // Classify the item
  always_comb begin
    q_cmd.ftype    = in_filter_type;
    q_cmd.raw      = in_raw_byte;
    q_cmd.no_prior = in_no_prior_row;
    q_cmd.last     = last;
    q_cmd.invalid  = (in_filter_type > FT_PAETH);
  end

  // Position within the row
  assign pos_nxt = last ? '0 : pos_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (q_push) begin
      pos_r <= pos_nxt;
    end
  end

endmodule

/* rtl/puf_back.sv */
module puf_back import puf_pkg::*; #(
  parameter int MAX_ROW_BYTES   = MAX_ROW_BYTES_DEF,
  parameter int MAX_PIXEL_BYTES = MAX_PIXEL_BYTES_DEF,
  localparam int PW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1,
  localparam int HW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [BPP_W-1:0] bytes_per_pixel,
  input  logic             q_empty,
  input  logic [PW-1:0]    q_pos,
  input  puf_cmd_t         q_cmd,
  output logic             q_pop,
  input  logic             o_full,
  output logic             o_push,
  output logic [PW-1:0]    o_pos,
  output puf_res_t         o_res
);

  // Previous row store, one byte per position
  logic [BYTE_W-1:0] row_mem [MAX_ROW_BYTES];

  logic [BYTE_W-1:0] left_hist_r [MAX_PIXEL_BYTES];
  logic [BYTE_W-1:0] up_hist_r   [MAX_PIXEL_BYTES];

  logic              b_v_r, b_v_nxt;
  logic [PW-1:0]     b_pos_r;
  puf_cmd_t          b_cmd_r;
  logic [BYTE_W-1:0] mem_q_r;
  logic              fwd_r;
  logic [BYTE_W-1:0] fwd_data_r;

  logic              b_fire;
  logic [BPP_W-1:0]  bpp_eff;
  logic [HW-1:0]     hidx;
  logic              left_ok;
  logic [BYTE_W-1:0] upper;
  logic [BYTE_W-1:0] na, nb, nc;
  logic [BYTE_W:0]   sum_ab;
  logic [BYTE_W-1:0] pred;
  logic [BYTE_W-1:0] recon;

  assign b_fire  = b_v_r & ~o_full;
  assign q_pop   = ~q_empty & (~b_v_r | b_fire);
  assign b_v_nxt = q_pop ? 1'b1 : (b_fire ? 1'b0 : b_v_r);

  // Pixel size clamped to 1..MAX_PIXEL_BYTES
  always_comb begin
    if (bytes_per_pixel == '0) begin
      bpp_eff = BPP_W'(1);
    end else if (32'(bytes_per_pixel) > MAX_PIXEL_BYTES) begin
      bpp_eff = BPP_W'(MAX_PIXEL_BYTES);
    end else begin
      bpp_eff = bytes_per_pixel;
    end
  end
  assign hidx = HW'(bpp_eff - 1'b1);

  // Neighbors a, b, c
  assign upper   = fwd_r ? fwd_data_r : mem_q_r;
  assign left_ok = (32'(b_pos_r) >= 32'(bpp_eff));
  assign na      = left_ok ? left_hist_r[hidx] : '0;
  assign nb      = b_cmd_r.no_prior ? '0 : upper;
  assign nc      = (left_ok && !b_cmd_r.no_prior) ? up_hist_r[hidx] : '0;
  assign sum_ab  = {1'b0, na} + {1'b0, nb};

  // Predictor select
  always_comb begin
    unique case (b_cmd_r.ftype)
      FT_SUB:   pred = na;
      FT_UP:    pred = nb;
      FT_AVG:   pred = sum_ab[BYTE_W:1];
      FT_PAETH: pred = paeth_pred(na, nb, nc);
      default:  pred = '0;
    endcase
  end
  assign recon = b_cmd_r.raw + pred;

  // Result toward the output queue
  assign o_push = b_fire;
  assign o_pos  = b_pos_r;
  always_comb begin
    o_res.recon   = recon;
    o_res.pred    = pred;
    o_res.last    = b_cmd_r.last;
    o_res.invalid = b_cmd_r.invalid;
  end

  // Compute stage valid and histories
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_hist_r[i] <= '0;
        up_hist_r[i]   <= '0;
      end
    end else begin
      b_v_r <= b_v_nxt;
      if (b_fire) begin
        left_hist_r[0] <= recon;
        up_hist_r[0]   <= upper;
        for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
          left_hist_r[i] <= left_hist_r[i-1];
          up_hist_r[i]   <= up_hist_r[i-1];
        end
      end
    end
  end

  // Row store read on pop, with bypass of the write of the same edge
  always_ff @(posedge clk) begin
    if (q_pop) begin
      b_pos_r    <= q_pos;
      b_cmd_r    <= q_cmd;
      mem_q_r    <= row_mem[q_pos];
      fwd_r      <= b_fire && (b_pos_r == q_pos);
      fwd_data_r <= recon;
    end
  end

  // Row store write
  always_ff @(posedge clk) begin
    if (b_fire) begin
      row_mem[b_pos_r] <= recon;
    end
  end

endmodule

/* rtl/png_scanline_unfilter_top.sv */
// Channel   Ports                                                 Accepted when
// input     in_filter_type, in_raw_byte, in_no_prior_row          in_push && !in_full
// result    out_recon_byte, out_predictor, out_byte_position,     out_pop && !out_empty
//           out_row_end, out_invalid_type
// config    cfg_wr_en, cfg_index, cfg_wdata                       cfg_wr_en
//
// One item per cycle sustained while neither side stalls; an item passes through the
// command queue, then the row store read into the compute stage, then the result queue,
// with registered left-neighbor feedback.
// Reset clears control state and histories; the row store needs no clearing pass.
// Either side may stall: two-entry queues on each side of the compute stage decouple them.
module png_scanline_unfilter_top import puf_pkg::*; #(
  parameter int MAX_ROW_BYTES   = MAX_ROW_BYTES_DEF,
  parameter int MAX_PIXEL_BYTES = MAX_PIXEL_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_index,
  input  logic [ROW_LEN_W-1:0] cfg_wdata,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [FTYPE_W-1:0]   in_filter_type,
  input  logic [BYTE_W-1:0]    in_raw_byte,
  input  logic                 in_no_prior_row,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [BYTE_W-1:0]    out_recon_byte,
  output logic [BYTE_W-1:0]    out_predictor,
  output logic [POS_OUT_W-1:0] out_byte_position,
  output logic                 out_row_end,
  output logic                 out_invalid_type
);

  localparam int PW    = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int CMD_W = PW + $bits(puf_cmd_t);
  localparam int RES_W = PW + $bits(puf_res_t);

  logic [BPP_W-1:0]     bpp_r;
  logic [ROW_LEN_W-1:0] row_len_r;

  logic          cq_push, cq_full, cq_pop, cq_empty;
  logic [PW-1:0] fr_pos, bk_pos, oq_pos;
  puf_cmd_t      fr_cmd, bk_cmd;
  logic          oq_push, oq_full;
  logic [PW-1:0] res_pos;
  puf_res_t      res, oq_res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r     <= BPP_RESET;
      row_len_r <= ROW_LEN_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_BPP:     bpp_r     <= cfg_wdata[BPP_W-1:0];
        CFG_ROW_LEN: row_len_r <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  puf_front #(
    .MAX_ROW_BYTES(MAX_ROW_BYTES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .row_length     (row_len_r),
    .in_push        (in_push),
    .in_filter_type (in_filter_type),
    .in_raw_byte    (in_raw_byte),
    .in_no_prior_row(in_no_prior_row),
    .q_full         (cq_full),
    .q_push         (cq_push),
    .q_pos          (fr_pos),
    .q_cmd          (fr_cmd)
  );

  assign in_full = cq_full;

  // Command queue between front and back
  puf_queue #(
    .WIDTH(CMD_W),
    .DEPTH(CMD_Q_DEPTH)
  ) u_cmd_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (cq_push),
    .wdata({fr_pos, fr_cmd}),
    .full (cq_full),
    .pop  (cq_pop),
    .rdata({bk_pos, bk_cmd}),
    .empty(cq_empty)
  );

  puf_back #(
    .MAX_ROW_BYTES  (MAX_ROW_BYTES),
    .MAX_PIXEL_BYTES(MAX_PIXEL_BYTES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .bytes_per_pixel(bpp_r),
    .q_empty        (cq_empty),
    .q_pos          (bk_pos),
    .q_cmd          (bk_cmd),
    .q_pop          (cq_pop),
    .o_full         (oq_full),
    .o_push         (oq_push),
    .o_pos          (res_pos),
    .o_res          (res)
  );

  // Result queue
  puf_queue #(
    .WIDTH(RES_W),
    .DEPTH(OUT_Q_DEPTH)
  ) u_out_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (oq_push),
    .wdata({res_pos, res}),
    .full (oq_full),
    .pop  (out_pop),
    .rdata({oq_pos, oq_res}),
    .empty(out_empty)
  );

  assign out_recon_byte    = oq_res.recon;
  assign out_predictor     = oq_res.pred;
  assign out_byte_position = POS_OUT_W'(32'(oq_pos));
  assign out_row_end       = oq_res.last;
  assign out_invalid_type  = oq_res.invalid;

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import puf_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_ITEMS = 1000;

  // One reconstructed byte as it leaves the block
  typedef struct packed {
    logic [BYTE_W-1:0]    recon;
    logic [BYTE_W-1:0]    pred;
    logic [POS_OUT_W-1:0] pos;
    logic                 row_end;
    logic                 invalid;
  } recon_item_t;

  // One row of the directed stimulus: a register write or an item
  typedef struct {
    bit                 is_cfg;
    logic               idx;
    logic [ROW_LEN_W-1:0] val;
    logic [FTYPE_W-1:0] ftype;
    logic [BYTE_W-1:0]  raw;
    logic               np;
    bit                 typed;
    recon_item_t        want;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic                 cfg_index = 1'b0;
  logic [ROW_LEN_W-1:0] cfg_wdata = '0;
  logic                 in_push = 1'b0;
  logic                 in_full;
  logic [FTYPE_W-1:0]   in_filter_type = '0;
  logic [BYTE_W-1:0]    in_raw_byte = '0;
  logic                 in_no_prior_row = 1'b0;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  logic [BYTE_W-1:0]    out_recon_byte;
  logic [BYTE_W-1:0]    out_predictor;
  logic [POS_OUT_W-1:0] out_byte_position;
  logic                 out_row_end;
  logic                 out_invalid_type;

  png_scanline_unfilter_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_filter_type   (in_filter_type),
    .in_raw_byte      (in_raw_byte),
    .in_no_prior_row  (in_no_prior_row),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_recon_byte   (out_recon_byte),
    .out_predictor    (out_predictor),
    .out_byte_position(out_byte_position),
    .out_row_end      (out_row_end),
    .out_invalid_type (out_invalid_type)
  );

  always #5 clk = ~clk;

  // Shadow state of the unfilter
  logic [BYTE_W-1:0]    row_mem [MAX_ROW_BYTES_DEF];
  bit                   written [MAX_ROW_BYTES_DEF];
  logic [BYTE_W-1:0]    left_hist [8];
  logic [BYTE_W-1:0]    up_hist [8];
  int unsigned          pos_now = 0;
  logic [BPP_W-1:0]     bpp_now = BPP_RESET;
  logic [ROW_LEN_W-1:0] len_now = ROW_LEN_RESET;

  recon_item_t expect_q[$];
  dir_row_t    dir_rows[$];
  recon_item_t head;
  int          errors = 0;
  int          cycles = 0;
  bit          steady = 1'b0;

  function automatic int unsigned eff_len();
    if (len_now == '0) return 1;
    if (32'(len_now) > MAX_ROW_BYTES_DEF) return MAX_ROW_BYTES_DEF;
    return 32'(len_now);
  endfunction

  function automatic logic [BYTE_W-1:0] pick_paeth(logic [BYTE_W-1:0] a,
                                                   logic [BYTE_W-1:0] b,
                                                   logic [BYTE_W-1:0] c);
    int ia, ib, ic, p, pa, pb, pc;
    ia = int'(a);
    ib = int'(b);
    ic = int'(c);
    p  = ia + ib - ic;
    pa = (p > ia) ? p - ia : ia - p;
    pb = (p > ib) ? p - ib : ib - p;
    pc = (p > ic) ? p - ic : ic - p;
    if (pa <= pb && pa <= pc) return a;
    if (pb <= pc) return b;
    return c;
  endfunction

  // Reconstruct one byte and advance the shadow state
  function automatic recon_item_t unfilter_byte(logic [FTYPE_W-1:0] ft,
                                                logic [BYTE_W-1:0] raw, logic np);
    int unsigned bpp, len, p;
    logic [BYTE_W-1:0] a, b, c, pred, up;
    recon_item_t r;
    bpp = (bpp_now == '0) ? 1 :
          (32'(bpp_now) > MAX_PIXEL_BYTES_DEF) ? MAX_PIXEL_BYTES_DEF : 32'(bpp_now);
    len = eff_len();
    p   = (pos_now >= MAX_ROW_BYTES_DEF) ? MAX_ROW_BYTES_DEF - 1 : pos_now;
    up  = row_mem[p];
    a   = (p >= bpp) ? left_hist[bpp-1] : 8'h00;
    b   = np ? 8'h00 : up;
    c   = (!np && p >= bpp) ? up_hist[bpp-1] : 8'h00;
    case (ft)
      FT_SUB:   pred = a;
      FT_UP:    pred = b;
      FT_AVG:   pred = 8'((9'(a) + 9'(b)) >> 1);
      FT_PAETH: pred = pick_paeth(a, b, c);
      default:  pred = 8'h00;
    endcase
    r.recon   = raw + pred;
    r.pred    = pred;
    r.pos     = p[POS_OUT_W-1:0];
    r.row_end = (p >= len - 1);
    r.invalid = (ft > FT_PAETH);
    row_mem[p] = r.recon;
    written[p] = 1'b1;
    for (int i = 7; i > 0; i--) begin
      left_hist[i] = left_hist[i-1];
      up_hist[i]   = up_hist[i-1];
    end
    left_hist[0] = r.recon;
    up_hist[0]   = up;
    pos_now = r.row_end ? 0 : p + 1;
    return r;
  endfunction

  // Directed table builders
  function automatic void append_row(dir_row_t d);
    dir_rows.insert(dir_rows.size(), d);
  endfunction

  function automatic dir_row_t item_row(logic [FTYPE_W-1:0] ft, logic [BYTE_W-1:0] raw,
                                        logic np);
    dir_row_t d;
    d = '{default: '0};
    d.ftype = ft;
    d.raw   = raw;
    d.np    = np;
    return d;
  endfunction

  function automatic void add_cfg(logic idx, logic [ROW_LEN_W-1:0] val);
    dir_row_t d;
    d = '{default: '0};
    d.is_cfg = 1'b1;
    d.idx    = idx;
    d.val    = val;
    append_row(d);
  endfunction

  function automatic void add_item(logic [FTYPE_W-1:0] ft, logic [BYTE_W-1:0] raw, logic np);
    append_row(item_row(ft, raw, np));
  endfunction

  function automatic void add_chk(logic [FTYPE_W-1:0] ft, logic [BYTE_W-1:0] raw, logic np,
                                  recon_item_t want);
    dir_row_t d;
    d = item_row(ft, raw, np);
    d.typed = 1'b1;
    d.want  = want;
    append_row(d);
  endfunction

  // Input side: random gaps outside steady phases, then hold the item until it is taken
  task automatic send_item(logic [FTYPE_W-1:0] ft, logic [BYTE_W-1:0] raw, logic np);
    while (!steady && $urandom_range(99) < 17) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push         <= 1'b1;
    in_filter_type  <= ft;
    in_raw_byte     <= raw;
    in_no_prior_row <= np;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  // Stop sending and wait for every outstanding item to come back
  task automatic drain_results();
    in_push <= 1'b0;
    while (expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [ROW_LEN_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_BPP) bpp_now = val[BPP_W-1:0];
    else len_now = val;
    @(posedge clk);
  endtask

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Result side: compare against the oldest expected item, pop at random outside steady phases
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (expect_q.size() == 0) begin
        $error("recon_byte: expected none, got %0h", out_recon_byte);
        errors++;
      end else begin
        head = expect_q.pop_front();
        check_field("recon_byte", 32'(head.recon), 32'(out_recon_byte));
        check_field("predictor", 32'(head.pred), 32'(out_predictor));
        check_field("byte_position", 32'(head.pos), 32'(out_byte_position));
        check_field("row_end", 32'(head.row_end), 32'(out_row_end));
        check_field("invalid_type", 32'(head.invalid), 32'(out_invalid_type));
      end
    end
    out_pop <= steady || ($urandom_range(99) >= 17);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    recon_item_t         got;
    logic [FTYPE_W-1:0]  ft, ft_row;
    logic [BYTE_W-1:0]   raw;
    logic                np, np_row;
    int                  rnd_items, phase, n_items;

    foreach (row_mem[i]) begin
      row_mem[i] = 8'h00;
      written[i] = 1'b0;
    end
    foreach (left_hist[i]) begin
      left_hist[i] = 8'h00;
      up_hist[i]   = 8'h00;
    end

    // Directed part. Reset setup: one byte per pixel, full-length rows.
    add_chk(FT_NONE, 8'h00, 1'b1, '{8'h00, 8'h00, 12'd0, 1'b0, 1'b0});
    add_chk(FT_SUB,  8'hFF, 1'b1, '{8'hFF, 8'h00, 12'd1, 1'b0, 1'b0});
    // sum wraps past 255
    add_chk(FT_SUB,  8'h01, 1'b1, '{8'h00, 8'hFF, 12'd2, 1'b0, 1'b0});
    // invalid filter types pass the byte through
    add_chk(3'd7,    8'hAB, 1'b1, '{8'hAB, 8'h00, 12'd3, 1'b0, 1'b1});
    add_chk(3'd5,    8'h55, 1'b1, '{8'h55, 8'h00, 12'd4, 1'b0, 1'b1});
    add_cfg(CFG_ROW_LEN, 13'd6);
    add_chk(FT_UP,   8'h10, 1'b1, '{8'h10, 8'h00, 12'd5, 1'b1, 1'b0});
    // second row reads the first one as its upper row
    add_cfg(CFG_BPP, 13'd2);
    add_item(FT_AVG,   8'h80, 1'b0);
    add_item(FT_PAETH, 8'h7F, 1'b0);
    add_item(FT_UP,    8'hFF, 1'b0);
    add_item(FT_AVG,   8'h01, 1'b0);
    add_item(FT_PAETH, 8'h00, 1'b0);
    add_item(FT_SUB,   8'h33, 1'b0);
    // zero register values act as one
    add_cfg(CFG_BPP, 13'd0);
    add_cfg(CFG_ROW_LEN, 13'd0);
    add_item(FT_PAETH, 8'hC3, 1'b0);
    add_item(FT_AVG,   8'h3C, 1'b0);
    // oversized register values clamp to the maximum
    add_cfg(CFG_BPP, 13'd15);
    add_cfg(CFG_ROW_LEN, 13'h1FFF);
    add_item(FT_PAETH, 8'h5A, 1'b0);
    add_item(FT_SUB,   8'hA5, 1'b0);
    add_item(FT_PAETH, 8'hFE, 1'b0);
    // row shrunk below the current position ends the row at once
    add_cfg(CFG_ROW_LEN, 13'd2);
    add_item(FT_PAETH, 8'h77, 1'b0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        drain_results();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_item(dir_rows[i].ftype, dir_rows[i].raw, dir_rows[i].np);
        got = unfilter_byte(dir_rows[i].ftype, dir_rows[i].raw, dir_rows[i].np);
        expect_q.insert(expect_q.size(), dir_rows[i].typed ? dir_rows[i].want : got);
      end
    end

    // Random part: phases of whole rows with random content between setups
    rnd_items = 0;
    phase = 0;
    while (rnd_items < RANDOM_ITEMS) begin
      drain_results();
      // the long row and a few later phases run with no idling on either side
      steady = (phase == 3) || (phase >= 8 && phase < 14);
      if (phase == 3) begin
        // one long partial row at full length
        write_reg(CFG_ROW_LEN, 13'(MAX_ROW_BYTES_DEF));
        n_items = 300;
      end else begin
        if (phase == 0 || $urandom_range(3) != 0) begin
          case ($urandom_range(5))
            0:       write_reg(CFG_BPP, 13'd1);
            1:       write_reg(CFG_BPP, 13'(MAX_PIXEL_BYTES_DEF));
            2:       write_reg(CFG_BPP, ($urandom_range(1) == 0) ? 13'd0 : 13'd15);
            default: write_reg(CFG_BPP, 13'($urandom_range(1, 8)));
          endcase
        end
        if (phase == 0 || $urandom_range(3) != 0) begin
          case ($urandom_range(7))
            0:       write_reg(CFG_ROW_LEN, 13'd1);
            1:       write_reg(CFG_ROW_LEN, 13'($urandom_range(2, 8)));
            default: write_reg(CFG_ROW_LEN, 13'($urandom_range(9, 40)));
          endcase
        end
        n_items = int'(eff_len() * $urandom_range(1, 4));
        // sometimes stop mid-row so the next setup lands inside a row
        if ($urandom_range(2) == 0) n_items += int'($urandom_range(0, eff_len()));
      end

      for (int k = 0; k < n_items; k++) begin
        if (pos_now == 0 || k == 0) begin
          ft_row = ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
          np_row = ($urandom_range(4) == 0);
        end
        if ($urandom_range(9) == 0) begin
          ft = 3'($urandom_range(7));
          np = 1'($urandom_range(1));
        end else begin
          ft = ft_row;
          np = np_row;
        end
        // never read a row store entry that holds nothing yet
        if (!written[pos_now]) np = 1'b1;
        raw = 8'($urandom_range(255));
        send_item(ft, raw, np);
        expect_q.insert(expect_q.size(), unfilter_byte(ft, raw, np));
      end
      rnd_items += n_items;
      phase++;
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/puf_pkg.sv
rtl/puf_queue.sv
rtl/puf_front.sv
rtl/puf_back.sv
rtl/png_scanline_unfilter_top.sv
tb/sv/tb.sv
